### src/rsbl_pkg.sv
// Package for the runstop button latch: item and result types, command codes,
// mode encoding and configuration register indexes. No dependencies.
`timescale 1ns / 1ps

package rsbl_pkg;

    localparam int unsigned NOW_W    = 32;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned HOLD_W   = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [HOLD_W-1:0] HOLD_RELEASE_RESET = 16'd2000;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_TRIGGER = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_BLINK   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STOP_ENABLE     = 2'd0,
        CFG_HOLD_RELEASE_MS = 2'd1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'b001,
        MODE_STOPPED = 3'b010,
        MODE_HOLD    = 3'b100
    } mode_t;

    localparam logic [1:0] MODE_CODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_CODE_STOPPED = 2'd1;
    localparam logic [1:0] MODE_CODE_HOLD    = 2'd2;

    typedef struct packed {
        logic [1:0]          cmd;
        logic                button_level;
        logic [NOW_W-1:0]    now_ms;
        logic [PERIOD_W-1:0] blink_period_ms;
    } item_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       stop_active;
        logic       led_on;
        logic       beep;
    } result_t;

    typedef struct packed {
        logic              stop_enable;
        logic [HOLD_W-1:0] hold_release_ms;
    } cfg_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] code;
        code = MODE_CODE_IDLE;
        case (m)
            MODE_STOPPED: code = MODE_CODE_STOPPED;
            MODE_HOLD:    code = MODE_CODE_HOLD;
            default:      code = MODE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

### src/rsbl_cmd_if.sv
// Command channel of the runstop button latch: valid/ready with item fields.
// Depends on rsbl_pkg for field widths.
`timescale 1ns / 1ps

interface rsbl_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     cmd;
    logic                           button_level;
    logic [rsbl_pkg::NOW_W-1:0]     now_ms;
    logic [rsbl_pkg::PERIOD_W-1:0]  blink_period_ms;

    modport source (output valid, cmd, button_level, now_ms, blink_period_ms,
                    input ready);
    modport sink   (input valid, cmd, button_level, now_ms, blink_period_ms,
                    output ready);
endinterface

### src/rsbl_res_if.sv
// Result channel of the runstop button latch: valid/ready with result fields.
// No dependencies.
`timescale 1ns / 1ps

interface rsbl_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       stop_active;
    logic       led_on;
    logic       beep;

    modport source (output valid, mode, stop_active, led_on, beep, input ready);
    modport sink   (input valid, mode, stop_active, led_on, beep, output ready);
endinterface

### src/rsbl_cfg_if.sv
// Configuration write channel of the runstop button latch: index and data.
// Depends on rsbl_pkg for field widths.
`timescale 1ns / 1ps

interface rsbl_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rsbl_pkg::CFG_IDX_W-1:0]   index;
    logic [rsbl_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/rsbl_core.sv
// Runstop state and result register: applies one item per step to the mode,
// button, trigger and LED state. Depends on rsbl_pkg.
`timescale 1ns / 1ps

module rsbl_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  rsbl_pkg::item_t   item,
    input  rsbl_pkg::cfg_t    cfg,
    output rsbl_pkg::result_t result
);

    rsbl_pkg::mode_t              mode_reg, mode_next;
    logic                         pressed_prev_reg, pressed_prev_next;
    logic                         trigger_pending_reg, trigger_pending_next;
    logic                         stop_flag_reg, stop_flag_next;
    logic                         led_state_reg, led_state_next;
    logic [rsbl_pkg::NOW_W-1:0]   last_toggle_reg, last_toggle_next;
    logic [rsbl_pkg::NOW_W-1:0]   hold_start_reg, hold_start_next;
    rsbl_pkg::result_t            result_reg, result_next;

    logic                         pressed;
    logic                         beep;
    logic [rsbl_pkg::NOW_W-1:0]   hold_elapsed;
    logic [rsbl_pkg::NOW_W-1:0]   blink_elapsed;
    logic                         hold_done;
    logic                         blink_due;

    assign pressed       = ~item.button_level;
    assign hold_elapsed  = item.now_ms - hold_start_reg;
    assign blink_elapsed = item.now_ms - last_toggle_reg;
    assign hold_done     = hold_elapsed >
                           {{(rsbl_pkg::NOW_W - rsbl_pkg::HOLD_W){1'b0}}, cfg.hold_release_ms};
    assign blink_due     = blink_elapsed >
                           {{(rsbl_pkg::NOW_W - rsbl_pkg::PERIOD_W){1'b0}}, item.blink_period_ms};

    always_comb
    begin
        mode_next            = mode_reg;
        pressed_prev_next    = pressed_prev_reg;
        trigger_pending_next = trigger_pending_reg;
        stop_flag_next       = stop_flag_reg;
        led_state_next       = led_state_reg;
        last_toggle_next     = last_toggle_reg;
        hold_start_next      = hold_start_reg;
        beep                 = 1'b0;

        case (item.cmd)
            rsbl_pkg::CMD_TICK:
            begin
                if ((!pressed_prev_reg && pressed) || trigger_pending_reg)
                begin
                    if (mode_reg == rsbl_pkg::MODE_IDLE)
                    begin
                        mode_next = rsbl_pkg::MODE_STOPPED;
                        beep      = 1'b1;
                    end
                    else if (mode_reg == rsbl_pkg::MODE_STOPPED && !trigger_pending_reg)
                    begin
                        hold_start_next = item.now_ms;
                        mode_next       = rsbl_pkg::MODE_HOLD;
                    end
                    trigger_pending_next = 1'b0;
                end
                else if (mode_reg == rsbl_pkg::MODE_HOLD)
                begin
                    if (pressed && hold_done)
                    begin
                        mode_next        = rsbl_pkg::MODE_IDLE;
                        beep             = 1'b1;
                        last_toggle_next = '0;
                    end
                    else if (!pressed)
                    begin
                        mode_next = rsbl_pkg::MODE_STOPPED;
                    end
                end
                pressed_prev_next = pressed;
                stop_flag_next    = (mode_next == rsbl_pkg::MODE_IDLE) ? 1'b0
                                                                       : cfg.stop_enable;
            end
            rsbl_pkg::CMD_TRIGGER:
            begin
                trigger_pending_next = 1'b1;
            end
            rsbl_pkg::CMD_CLEAR:
            begin
                mode_next            = rsbl_pkg::MODE_IDLE;
                stop_flag_next       = 1'b0;
                trigger_pending_next = 1'b0;
            end
            default:
            begin
                if (blink_due)
                begin
                    last_toggle_next = item.now_ms;
                    led_state_next   = ~led_state_reg;
                end
            end
        endcase

        result_next.mode        = rsbl_pkg::mode_code(mode_next);
        result_next.stop_active = stop_flag_next;
        result_next.led_on      = led_state_next;
        result_next.beep        = beep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= rsbl_pkg::MODE_IDLE;
            pressed_prev_reg    <= 1'b0;
            trigger_pending_reg <= 1'b0;
            stop_flag_reg       <= 1'b0;
            led_state_reg       <= 1'b0;
            last_toggle_reg     <= '0;
        end
        else if (step)
        begin
            mode_reg            <= mode_next;
            pressed_prev_reg    <= pressed_prev_next;
            trigger_pending_reg <= trigger_pending_next;
            stop_flag_reg       <= stop_flag_next;
            led_state_reg       <= led_state_next;
            last_toggle_reg     <= last_toggle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            hold_start_reg <= hold_start_next;
            result_reg     <= result_next;
        end
    end

    assign result = result_reg;

endmodule

### src/runstop_button_latch.sv
// Top level of the runstop button latch: channel handshakes, input register
// and configuration registers. Depends on rsbl_pkg, the channel interfaces
// and rsbl_core.
`timescale 1ns / 1ps

// The block takes one item per clock cycle and returns exactly one result
// item for each, in order. An accepted item goes first into the input
// register and then into the result register, with the state update done
// in a single pass between them. Both registers keep moving while the
// result side is ready, so full rate is sustained; a stall on the result
// side holds both and then drops ready on the command side. Configuration
// writes are always ready and should be made only while no item is in
// flight.
module runstop_button_latch
(
    input  logic       clk,
    input  logic       rst_n,
    rsbl_cmd_if.sink   cmd_ch,
    rsbl_res_if.source res_ch,
    rsbl_cfg_if.sink   cfg_ch
);

    logic                  in_valid_reg, in_valid_next;
    rsbl_pkg::item_t       in_item_reg;
    logic                  res_valid_reg, res_valid_next;
    rsbl_pkg::cfg_t        cfg_reg;
    rsbl_pkg::result_t     result;
    logic                  in_accept;
    logic                  advance;

    assign advance      = in_valid_reg && (!res_valid_reg || res_ch.ready);
    assign cmd_ch.ready = !in_valid_reg || advance;
    assign in_accept    = cmd_ch.valid && cmd_ch.ready;
    assign cfg_ch.ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ch.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg.cmd             <= cmd_ch.cmd;
            in_item_reg.button_level    <= cmd_ch.button_level;
            in_item_reg.now_ms          <= cmd_ch.now_ms;
            in_item_reg.blink_period_ms <= cmd_ch.blink_period_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_enable     <= 1'b0;
            cfg_reg.hold_release_ms <= rsbl_pkg::HOLD_RELEASE_RESET;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            case (cfg_ch.index)
                rsbl_pkg::CFG_STOP_ENABLE:
                begin
                    cfg_reg.stop_enable <= cfg_ch.data[0];
                end
                rsbl_pkg::CFG_HOLD_RELEASE_MS:
                begin
                    cfg_reg.hold_release_ms <= cfg_ch.data[rsbl_pkg::HOLD_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    rsbl_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign res_ch.valid       = res_valid_reg;
    assign res_ch.mode        = result.mode;
    assign res_ch.stop_active = result.stop_active;
    assign res_ch.led_on      = result.led_on;
    assign res_ch.beep        = result.beep;

endmodule
